// ----- sv/fft_pkg.sv -----
// Package with the shared types and constants of the fern forest trainer.
package fft_pkg;
  localparam int TREE_COUNT = 10;
  localparam int LEAF_BITS = 13;
  localparam int CNT_W = 16;
  localparam int POST_W = 16;
  localparam int VOTE_W = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [POST_W-1:0] POST_MAX = '1;
  localparam int HALF_ONE = 32768;

  // Control between the top-level sequencer and the lanes.
  typedef struct packed {
    logic rd;      // read the leaf entries at the latched codes
    logic start;   // begin the update of the latched leaf
    logic label;   // 1 positive, 0 negative
  } lane_ctl_t;
endpackage

// ----- sv/fft_div.sv -----
// Restoring divider that yields floor(p * 65536 / (p + n)), one bit a cycle.
module fft_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] p,
  input  logic [15:0] n,
  output logic        done,
  output logic [15:0] q
);
  logic [16:0] den;
  logic [17:0] rem;
  logic [15:0] quo;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] trial;
  logic        pz;

  assign trial = {rem[16:0], 1'b0} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        den <= {1'b0, p} + {1'b0, n};
        pz <= (p == '0);
        // The numerator is p followed by sixteen zeros: start with p as remainder.
        rem <= {2'b0, p};
        quo <= '0;
        cnt <= 5'd16;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial;
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[16:0], 1'b0};
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // When n is zero the remainder stays at den, so every quotient bit is one: the saturated value.
  always_comb begin
    if (pz) q = '0;
    else q = quo;
  end
endmodule

// ----- sv/fft_lane.sv -----
// One tree lane: leaf tables, posterior read and the counter update.
module fft_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  fft_pkg::lane_ctl_t            ctl,
  input  logic [fft_pkg::LEAF_BITS-1:0] leaf,
  input  logic                          clr_en,
  input  logic [fft_pkg::LEAF_BITS-1:0] clr_addr,
  output logic [15:0]                   post,
  output logic                          upd_done
);
  import fft_pkg::*;
  localparam int DEPTH = 1 << LEAF_BITS;
  logic [CNT_W-1:0]  pmem [DEPTH];
  logic [CNT_W-1:0]  nmem [DEPTH];
  logic [POST_W-1:0] qmem [DEPTH];
  logic [CNT_W-1:0]  prd, nrd;
  logic [CNT_W-1:0]  pnew, nnew;
  logic [1:0]        ph;
  logic              lab;
  logic              dstart, ddone;
  logic [15:0]       dq;

  always_ff @(posedge clk) begin
    if (clr_en) begin
      pmem[clr_addr] <= '0;
      nmem[clr_addr] <= '0;
      qmem[clr_addr] <= '0;
    end else begin
      if (ctl.rd || ctl.start) begin
        post <= qmem[leaf];
        prd <= pmem[leaf];
        nrd <= nmem[leaf];
      end
      if (ph == 2'd1) begin
        if (lab) pmem[leaf] <= pnew;
        else nmem[leaf] <= nnew;
      end
      if (ddone) qmem[leaf] <= dq;
    end
  end

  assign pnew = (lab && prd != CNT_MAX) ? prd + 16'd1 : prd;
  assign nnew = (!lab && nrd != CNT_MAX) ? nrd + 16'd1 : nrd;
  assign dstart = (ph == 2'd1);
  assign upd_done = ddone;

  always_ff @(posedge clk) begin
    if (rst) ph <= 2'd0;
    else if (ctl.start) begin
      ph <= 2'd1;
      lab <= ctl.label;
    end else if (ph == 2'd1) ph <= 2'd2;
    else if (ddone) ph <= 2'd0;
  end

  fft_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .p(pnew), .n(nnew),
    .done(ddone), .q(dq)
  );
endmodule

// ----- sv/fft_merge.sv -----
// Merging stage: sums the lane posteriors and decides whether to train.
module fft_merge (
  input  logic                             clk,
  input  logic [fft_pkg::TREE_COUNT*16-1:0] posts,
  input  logic [15:0]                      thr,
  input  logic                             action,
  input  logic                             label,
  output logic [19:0]                      vote,
  output logic                             train
);
  import fft_pkg::*;
  logic [19:0] s;
  logic [23:0] lim;
  always_comb begin
    s = '0;
    for (int t = 0; t < TREE_COUNT; t++) s = s + {4'b0, posts[t*16 +: 16]};
  end
  assign lim = 24'(thr) * 24'(TREE_COUNT);
  always_ff @(posedge clk) begin
    vote <= s;
    if (!action) train <= 1'b0;
    else if (label) train <= {4'b0, s} <= lim;
    else train <= 24'(s) >= 24'(TREE_COUNT * HALF_ONE);
  end
endmodule

// ----- sv/fern_forest_trainer_core.sv -----
// Fern forest classifier with online leaf training.
// After reset a clearing pass over every leaf address wipes the leaf tables, while no item is
// accepted. Each tree has its own lane holding its tables, so all posteriors are read in parallel
// and summed in one merging stage. A classify-only item presents its result after the lane read,
// the merge and the decision; a training item presents it once the bit-serial posterior divider
// in each lane has finished the update. The next item is accepted in the cycle after the result
// leaves, so the core takes no new item until the result of the last one has left.
module fern_forest_trainer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic        label,
  input  logic [12:0] leaf_0, leaf_1, leaf_2, leaf_3, leaf_4,
  input  logic [12:0] leaf_5, leaf_6, leaf_7, leaf_8, leaf_9,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] vote_sum,
  output logic        trained
);
  import fft_pkg::*;
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_SUM = 3'd3,
                         S_DEC = 3'd4, S_UPD = 3'd5, S_OUT = 3'd6;
  logic [2:0] state;
  logic [15:0] thr;
  logic [LEAF_BITS-1:0] clr_addr;
  logic act_r, lab_r;
  logic [LEAF_BITS-1:0] leaves [TREE_COUNT];
  logic [12:0] lin [10];
  logic [TREE_COUNT*16-1:0] posts;
  logic [TREE_COUNT-1:0] done_v;
  logic [19:0] vote;
  logic train;
  lane_ctl_t ctl;

  assign lin = '{leaf_0, leaf_1, leaf_2, leaf_3, leaf_4, leaf_5, leaf_6, leaf_7, leaf_8, leaf_9};
  assign in_stall = (state != S_IDLE);
  assign ctl.rd = (state == S_RD);
  assign ctl.start = (state == S_DEC) && train;
  assign ctl.label = lab_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      thr <= 16'd39322;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            act_r <= action;
            lab_r <= label;
            for (int t = 0; t < TREE_COUNT; t++) leaves[t] <= lin[t][LEAF_BITS-1:0];
            state <= S_RD;
          end
        end
        S_RD: state <= S_SUM;
        S_SUM: state <= S_DEC;
        S_DEC: begin
          vote_sum <= vote;
          trained <= train;
          if (train) state <= S_UPD;
          else begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_UPD: begin
          // All lanes start together, so they finish together.
          if (&done_v) begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  for (genvar t = 0; t < TREE_COUNT; t++) begin : g_lane
    fft_lane u_lane (
      .clk(clk), .rst(rst), .ctl(ctl), .leaf(leaves[t]),
      .clr_en(state == S_CLR), .clr_addr(clr_addr),
      .post(posts[t*16 +: 16]), .upd_done(done_v[t])
    );
  end

  fft_merge u_merge (
    .clk(clk), .posts(posts), .thr(thr), .action(act_r), .label(lab_r),
    .vote(vote), .train(train)
  );
endmodule
